[rtl/fixed_point_alu_defines.svh]
// ----------------------------------------------------------------------------
// fixed_point_alu_defines
// assertion macros used by the fixed-point alu
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpa check failed");

// next-cycle implication, disabled in reset
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpa check failed");

`endif

[rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// opcodes, widths and stage types of the fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_EQ       = 4'd4,
    OP_NE       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_GT       = 4'd8,
    OP_LT       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } func_t;

  // result side state carried alongside the divider
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              dz;
    logic              flag;
    logic [DATA_W-1:0] res;
  } side_t;

endpackage

[rtl/fpa_divider.sv]
// ----------------------------------------------------------------------------
// fpa_divider
// pipelined restoring divider, one quotient bit per stage, low word kept
// ----------------------------------------------------------------------------
module fpa_divider #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fpa_pkg::DATA_W-1:0] mag_a,
  input  logic [fpa_pkg::DATA_W-1:0] mag_b,
  input  logic                      neg,
  output logic [fpa_pkg::DATA_W-1:0] quo
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int NSTG = DW + FRAC_BITS;

  logic [DW-1:0] rem_s [0:NSTG];
  logic [DW-1:0] quo_s [0:NSTG];
  logic [DW-1:0] dvd_s [0:NSTG];
  logic [DW-1:0] dvs_s [0:NSTG];
  logic          neg_s [0:NSTG];

  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign dvd_s[0] = mag_a;
  assign dvs_s[0] = mag_b;
  assign neg_s[0] = neg;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int J = NSTG - 1 - k;
    logic          in_bit;
    logic [DW:0]   trial;
    logic          ge;

    if (J >= FRAC_BITS) begin : g_bit
      assign in_bit = dvd_s[k][J-FRAC_BITS];
    end else begin : g_zero
      assign in_bit = 1'b0;
    end

    assign trial = {rem_s[k], in_bit};
    assign ge    = trial >= {1'b0, dvs_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? DW'(trial - {1'b0, dvs_s[k]}) : trial[DW-1:0];
        quo_s[k+1] <= {quo_s[k][DW-2:0], ge};
        dvd_s[k+1] <= dvd_s[k];
        dvs_s[k+1] <= dvs_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  assign quo = neg_s[NSTG] ? (~quo_s[NSTG] + DW'(1)) : quo_s[NSTG];

endmodule

[rtl/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// pipelined signed fixed-point alu with multiply and divide
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   func, operand_a, operand_b
// m_axis   out  result, flag, div_by_zero
//
// one transaction per cycle unless the pipeline holds for m_axis_tready
// the divider sets the depth, one quotient bit per stage
// rst is synchronous and clears all valid bits
// the whole pipeline holds while a result waits on m_axis_tready
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // func, operand_a, operand_b, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result, flag, div_by_zero, zero pad
);

  `include "fixed_point_alu_defines.svh"

  localparam int DW = fpa_pkg::DATA_W;
  localparam int NSTG = DW + FRAC_BITS;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: input register
  logic              v1;
  fpa_pkg::func_t    func1;
  logic signed [DW-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      func1 <= fpa_pkg::func_t'(s_axis_tdata[3:0]);
      a1    <= s_axis_tdata[35:4];
      b1    <= s_axis_tdata[67:36];
    end
  end

  // stage 2: simple ops, product, divider operands
  logic [DW-1:0]        r1;
  logic                 f1;
  logic signed [2*DW-1:0] prod2;
  logic                 mul2;
  fpa_pkg::side_t       s2;
  logic [DW-1:0]        mag_a2, mag_b2;
  logic                 neg2;

  always_comb begin
    r1 = '0;
    f1 = 1'b0;
    unique case (func1)
      fpa_pkg::OP_ADD:      r1 = a1 + b1;
      fpa_pkg::OP_SUB:      r1 = a1 - b1;
      fpa_pkg::OP_EQ:       f1 = a1 == b1;
      fpa_pkg::OP_NE:       f1 = a1 != b1;
      fpa_pkg::OP_GE:       f1 = a1 >= b1;
      fpa_pkg::OP_LE:       f1 = a1 <= b1;
      fpa_pkg::OP_GT:       f1 = a1 > b1;
      fpa_pkg::OP_LT:       f1 = a1 < b1;
      fpa_pkg::OP_MIN:      r1 = (a1 <= b1) ? a1 : b1;
      fpa_pkg::OP_MAX:      r1 = (a1 >= b1) ? a1 : b1;
      fpa_pkg::OP_INC:      r1 = a1 + DW'(1);
      fpa_pkg::OP_DEC:      r1 = a1 - DW'(1);
      fpa_pkg::OP_FROM_INT: r1 = a1 << FRAC_BITS;
      fpa_pkg::OP_TO_INT:   r1 = a1 >>> FRAC_BITS;
      default:              r1 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= v1;
    end
    if (en) begin
      prod2     <= (2*DW)'(a1) * (2*DW)'(b1);
      mul2      <= func1 == fpa_pkg::OP_MUL;
      s2.is_div <= func1 == fpa_pkg::OP_DIV;
      s2.dz     <= (func1 == fpa_pkg::OP_DIV) && (b1 == '0);
      s2.flag   <= f1;
      s2.res    <= r1;
      mag_a2    <= a1[DW-1] ? (~a1 + DW'(1)) : a1;
      mag_b2    <= b1[DW-1] ? (~b1 + DW'(1)) : b1;
      neg2      <= a1[DW-1] ^ b1[DW-1];
    end
  end

  logic [DW-1:0] quo;

  fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .en    (en),
    .mag_a (mag_a2),
    .mag_b (mag_b2),
    .neg   (neg2),
    .quo   (quo)
  );

  // stage 3 applies the product shift, then a delay line to match the divider
  logic signed [2*DW-1:0] psh;
  fpa_pkg::side_t         dl [1:NSTG];

  assign psh = prod2 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      dl[1].valid <= 1'b0;
    end else if (en) begin
      dl[1].valid <= s2.valid;
    end
    if (en) begin
      dl[1].is_div <= s2.is_div;
      dl[1].dz     <= s2.dz;
      dl[1].flag   <= s2.flag;
      dl[1].res    <= mul2 ? psh[DW-1:0] : s2.res;
    end
  end

  for (genvar i = 2; i <= NSTG; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dl[i].valid <= 1'b0;
      end else if (en) begin
        dl[i].valid <= dl[i-1].valid;
      end
      if (en) begin
        dl[i].is_div <= dl[i-1].is_div;
        dl[i].dz     <= dl[i-1].dz;
        dl[i].flag   <= dl[i-1].flag;
        dl[i].res    <= dl[i-1].res;
      end
    end
  end

  // output register
  logic [DW-1:0] res_o;
  logic          flag_o, dz_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dl[NSTG].valid;
    end
    if (en) begin
      flag_o <= dl[NSTG].flag;
      dz_o   <= dl[NSTG].dz;
      if (dl[NSTG].is_div) begin
        res_o <= dl[NSTG].dz ? '0 : quo;
      end else begin
        res_o <= dl[NSTG].res;
      end
    end
  end

  assign m_axis_tdata = {6'd0, dz_o, flag_o, res_o};

  `FPA_ASSERT_NOW(a_dz_zero, m_axis_tvalid && dz_o, res_o == '0 && !flag_o)
  `FPA_ASSERT_NOW(a_flag_excl, m_axis_tvalid, !(flag_o && dz_o))
  `FPA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(res_o))

endmodule
